[rtl/prss_pkg.sv]
`timescale 1ns / 1ps
// prss_pkg: shared types and constants of the protobuf record stream splitter.
// No dependencies.
package prss_pkg;

   localparam int MAX_VARINT_BYTES_DEF = 10;

   localparam logic [63:0] FIRST_TAG_RST   = 64'd10;
   localparam logic [63:0] SECOND_TAG_RST  = 64'd18;
   localparam logic [30:0] MAX_REC_LEN_RST = 31'd10485760;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_FIRST_TAG   = 2'd0;
   localparam csr_index_type CSR_SECOND_TAG  = 2'd1;
   localparam csr_index_type CSR_MAX_REC_LEN = 2'd2;

   typedef logic [2:0] status_type;
   localparam status_type ST_PAYLOAD     = 3'd0;
   localparam status_type ST_EMPTY       = 3'd1;
   localparam status_type ST_CLEAN_END   = 3'd2;
   localparam status_type ST_EARLY_END   = 3'd3;
   localparam status_type ST_VARINT_LONG = 3'd4;
   localparam status_type ST_BAD_WIRE    = 3'd5;
   localparam status_type ST_REC_LARGE   = 3'd6;
   localparam status_type ST_SKIP_LARGE  = 3'd7;

   typedef logic [2:0] wire_kind_type;
   localparam wire_kind_type WT_VARINT = 3'd0;
   localparam wire_kind_type WT_FIXED64 = 3'd1;
   localparam wire_kind_type WT_LEN    = 3'd2;
   localparam wire_kind_type WT_FIXED32 = 3'd5;

   typedef struct packed {
      logic       last_of_record;
      logic [7:0] payload_byte;
      logic       record_type;
      status_type status;
   } result_type;

   typedef struct packed {
      logic [63:0] first_record_tag;
      logic [63:0] second_record_tag;
      logic [30:0] max_record_length;
   } cfg_type;

endpackage

[rtl/prss_csr.sv]
`timescale 1ns / 1ps
// prss_csr: configuration registers (record tags, record length limit).
// Depends on prss_pkg.
module prss_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  prss_pkg::csr_index_type csr_index,
   input  logic [63:0]            csr_wdata,
   output prss_pkg::cfg_type      cfg
);

   prss_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_record_tag  <= prss_pkg::FIRST_TAG_RST;
         cfg_ff.second_record_tag <= prss_pkg::SECOND_TAG_RST;
         cfg_ff.max_record_length <= prss_pkg::MAX_REC_LEN_RST;
      end else if (csr_we) begin
         case (csr_index)
            prss_pkg::CSR_FIRST_TAG:   cfg_ff.first_record_tag  <= csr_wdata;
            prss_pkg::CSR_SECOND_TAG:  cfg_ff.second_record_tag <= csr_wdata;
            prss_pkg::CSR_MAX_REC_LEN: cfg_ff.max_record_length <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/prss_parser.sv]
`timescale 1ns / 1ps
// prss_parser: field scanner state and the per-byte next-state and result logic.
// Depends on prss_pkg.
module prss_parser #(
   parameter int MaxVarintBytes = prss_pkg::MAX_VARINT_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            data_byte,
   input  logic                  stream_end,
   input  prss_pkg::cfg_type     cfg,
   output logic                  rslt_valid,
   output prss_pkg::result_type  rslt
);

   typedef enum logic [2:0] {
      PH_TAG, PH_LEN, PH_PAYLOAD, PH_SKIPVAR, PH_SKIPLEN, PH_SKIPBYTES, PH_ERROR
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [30:0] rem_ff, rem_in;
   logic        rtype_ff, rtype_in;

   logic [5:0]  shamt;
   logic [63:0] acc_new;
   logic [3:0]  cnt_inc;
   logic        vdone;
   logic        vlong;
   logic [30:0] rem_dec;

   assign shamt   = 6'({2'b00, cnt_ff} * 6'd7);
   assign acc_new = acc_ff | ({57'd0, data_byte[6:0]} << shamt);
   assign cnt_inc = cnt_ff + 4'd1;
   assign vdone   = !data_byte[7];
   assign vlong   = !vdone && (cnt_inc >= 4'(MaxVarintBytes));
   assign rem_dec = rem_ff - {30'd0, (rem_ff != 31'd0)};

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      rtype_in   = rtype_ff;
      rslt_valid = 1'b0;
      rslt       = '0;
      if (stream_end) begin
         phase_in = PH_TAG;
         acc_in   = '0;
         cnt_in   = '0;
         rem_in   = '0;
         rtype_in = 1'b0;
         if (phase_ff != PH_ERROR) begin
            rslt_valid  = 1'b1;
            rslt.status = (phase_ff == PH_TAG && cnt_ff == 4'd0) ?
                          prss_pkg::ST_CLEAN_END : prss_pkg::ST_EARLY_END;
         end
      end else begin
         case (phase_ff)
            PH_TAG, PH_LEN, PH_SKIPVAR, PH_SKIPLEN: begin
               if (vlong) begin
                  phase_in         = PH_ERROR;
                  rslt_valid       = 1'b1;
                  rslt.status      = prss_pkg::ST_VARINT_LONG;
                  rslt.record_type = (phase_ff == PH_LEN) ? rtype_ff : 1'b0;
               end else if (!vdone) begin
                  acc_in = acc_new;
                  cnt_in = cnt_inc;
               end else begin
                  acc_in = '0;
                  cnt_in = '0;
                  case (phase_ff)
                     PH_TAG: begin
                        if (acc_new == cfg.first_record_tag) begin
                           rtype_in = 1'b0;
                           phase_in = PH_LEN;
                        end else if (acc_new == cfg.second_record_tag) begin
                           rtype_in = 1'b1;
                           phase_in = PH_LEN;
                        end else begin
                           case (acc_new[2:0])
                              prss_pkg::WT_VARINT: phase_in = PH_SKIPVAR;
                              prss_pkg::WT_FIXED64: begin
                                 rem_in   = 31'd8;
                                 phase_in = PH_SKIPBYTES;
                              end
                              prss_pkg::WT_LEN: phase_in = PH_SKIPLEN;
                              prss_pkg::WT_FIXED32: begin
                                 rem_in   = 31'd4;
                                 phase_in = PH_SKIPBYTES;
                              end
                              default: begin
                                 phase_in    = PH_ERROR;
                                 rslt_valid  = 1'b1;
                                 rslt.status = prss_pkg::ST_BAD_WIRE;
                              end
                           endcase
                        end
                     end
                     PH_LEN: begin
                        if (acc_new == 64'd0) begin
                           phase_in         = PH_TAG;
                           rslt_valid       = 1'b1;
                           rslt.status      = prss_pkg::ST_EMPTY;
                           rslt.record_type = rtype_ff;
                        end else if (acc_new > {33'd0, cfg.max_record_length}) begin
                           phase_in         = PH_ERROR;
                           rslt_valid       = 1'b1;
                           rslt.status      = prss_pkg::ST_REC_LARGE;
                           rslt.record_type = rtype_ff;
                        end else begin
                           rem_in   = acc_new[30:0];
                           phase_in = PH_PAYLOAD;
                        end
                     end
                     PH_SKIPVAR: phase_in = PH_TAG;
                     default: begin
                        if (|acc_new[63:31]) begin
                           phase_in    = PH_ERROR;
                           rslt_valid  = 1'b1;
                           rslt.status = prss_pkg::ST_SKIP_LARGE;
                        end else begin
                           rem_in   = acc_new[30:0];
                           phase_in = (acc_new[30:0] == 31'd0) ? PH_TAG : PH_SKIPBYTES;
                        end
                     end
                  endcase
               end
            end
            PH_PAYLOAD: begin
               rem_in              = rem_dec;
               rslt_valid          = 1'b1;
               rslt.status         = prss_pkg::ST_PAYLOAD;
               rslt.record_type    = rtype_ff;
               rslt.payload_byte   = data_byte;
               rslt.last_of_record = (rem_dec == 31'd0);
               if (rem_dec == 31'd0) begin
                  phase_in = PH_TAG;
               end
            end
            PH_SKIPBYTES: begin
               rem_in = rem_dec;
               if (rem_dec == 31'd0) begin
                  phase_in = PH_TAG;
               end
            end
            default: phase_in = PH_ERROR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         rtype_ff <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
         rtype_ff <= rtype_in;
      end
   end

endmodule

[rtl/prss_out_buf.sv]
`timescale 1ns / 1ps
// prss_out_buf: two-entry result buffer that decouples the parser from rsp backpressure.
// Depends on prss_pkg.
module prss_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  prss_pkg::result_type push_data,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output prss_pkg::result_type out_data
);

   prss_pkg::result_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign space     = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

[rtl/protobuf_record_stream_splitter.sv]
`timescale 1ns / 1ps
// protobuf_record_stream_splitter: top level of the protobuf field scanner.
// The parser state update is a single registered step; each result reaches rsp through the buffer.
// Throughput: one byte per cycle while the result buffer has space (req_tready high).
// A two-entry result buffer lets requests keep flowing while a result waits on rsp.
// Reset (synchronous, active high) returns the parser to tag scanning and the registers to defaults.
module protobuf_record_stream_splitter #(
   parameter int MaxVarintBytes = prss_pkg::MAX_VARINT_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] data_byte
   input  logic                    req_tlast,   // stream_end
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata,   // [2:0] status, [10:3] payload_byte
   output logic                    rsp_tuser,   // record_type
   output logic                    rsp_tlast,   // last_of_record
   input  logic                    csr_we,
   input  prss_pkg::csr_index_type csr_index,
   input  logic [63:0]             csr_wdata
);

   prss_pkg::cfg_type    cfg;
   prss_pkg::result_type rslt, rsp_item;
   logic                 rslt_valid;
   logic                 take;

   assign take = req_tvalid && req_tready;

   prss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   prss_parser #(
      .MaxVarintBytes (MaxVarintBytes)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .data_byte  (req_tdata),
      .stream_end (req_tlast),
      .cfg        (cfg),
      .rslt_valid (rslt_valid),
      .rslt       (rslt)
   );

   prss_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (take && rslt_valid),
      .push_data (rslt),
      .space     (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_item)
   );

   assign rsp_tdata = {5'd0, rsp_item.payload_byte, rsp_item.status};
   assign rsp_tuser = rsp_item.record_type;
   assign rsp_tlast = rsp_item.last_of_record;

   // full buffer always has something to show
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("buffer full with no result shown");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[2:0] == prss_pkg::ST_PAYLOAD)
      else $error("last mark on a non-payload result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != prss_pkg::ST_PAYLOAD |-> rsp_tdata[10:3] == 8'd0)
      else $error("payload byte set on a non-payload result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[2:0] == prss_pkg::ST_PAYLOAD || rsp_tdata[2:0] == prss_pkg::ST_EMPTY ||
         rsp_tdata[2:0] == prss_pkg::ST_REC_LARGE || rsp_tdata[2:0] == prss_pkg::ST_VARINT_LONG)
      else $error("record type on a result that carries none");

endmodule
